FILE: src/gdo_pkg.sv
`timescale 1ns / 1ps

package gdo_pkg;

  localparam int BASE_YEAR_DEF = 1900;
  localparam int YEAR_SPAN_DEF = 512;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 12;
  localparam int OFF_W     = 19;
  localparam int WDAY_W    = 3;
  localparam int YDAY_W    = 9;
  localparam int NUM_MONTHS = 12;

  // One queued transaction: the source date, the offset and the front's verdict.
  typedef struct packed {
    logic [DAY_W-1:0]       day;
    logic [MONTH_W-1:0]     month;
    logic [YEAR_W-1:0]      year;
    logic signed [OFF_W-1:0] off;
    logic                   bad;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR_IN,
    ST_MONTH_IN,
    ST_ADD,
    ST_YEAR_OUT,
    ST_MONTH_OUT,
    ST_DONE
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: src/gdo_ifs.sv
`timescale 1ns / 1ps

interface gdo_in_if;
  logic                                valid;
  logic                                ready;
  logic [gdo_pkg::DAY_W-1:0]           in_day;
  logic [gdo_pkg::MONTH_W-1:0]         in_month;
  logic [gdo_pkg::YEAR_W-1:0]          in_year;
  logic signed [gdo_pkg::OFF_W-1:0]    offset_days;

  modport source (output valid, in_day, in_month, in_year, offset_days, input ready);
  modport sink   (input valid, in_day, in_month, in_year, offset_days, output ready);
endinterface

interface gdo_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdo_pkg::DAY_W-1:0]     out_day;
  logic [gdo_pkg::MONTH_W-1:0]   out_month;
  logic [gdo_pkg::YEAR_W-1:0]    out_year;
  logic [gdo_pkg::WDAY_W-1:0]    out_weekday;
  logic [gdo_pkg::YDAY_W-1:0]    out_year_day;
  logic                          error;

  modport source (output valid, out_day, out_month, out_year, out_weekday, out_year_day,
                  error, input ready);
  modport sink   (input valid, out_day, out_month, out_year, out_weekday, out_year_day,
                  error, output ready);
endinterface

FILE: src/gdo_front.sv
`timescale 1ns / 1ps

module gdo_front #(
  parameter int BASE_YEAR = gdo_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = gdo_pkg::YEAR_SPAN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  gdo_in_if.sink         in_ch,
  input  logic           q_pop,
  output logic           q_valid,
  output gdo_pkg::item_t q_item
);

  localparam int YW_RAW = $clog2(BASE_YEAR + YEAR_SPAN + 1);
  localparam int YW     = (YW_RAW > gdo_pkg::YEAR_W) ? YW_RAW : gdo_pkg::YEAR_W;

  logic [YW-1:0]  year_ext;
  logic           bad;
  logic           push;
  gdo_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign year_ext = YW'(in_ch.in_year);

  // Everything that can be judged without the calendar walk is judged here;
  // the day is checked against the month length later, once leap is known.
  assign bad = (year_ext < YW'(BASE_YEAR)) ||
               (year_ext >= YW'(BASE_YEAR + YEAR_SPAN)) ||
               (in_ch.in_month == '0) ||
               (in_ch.in_month > gdo_pkg::MONTH_W'(gdo_pkg::NUM_MONTHS)) ||
               (in_ch.in_day == '0);

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].day   <= in_ch.in_day;
      q_r[wr_ptr_r].month <= in_ch.in_month;
      q_r[wr_ptr_r].year  <= in_ch.in_year;
      q_r[wr_ptr_r].off   <= in_ch.offset_days;
      q_r[wr_ptr_r].bad   <= bad;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != 2'd0))
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |=> (count_r != 2'd3))
    else $error("queue count overflow");
`endif

endmodule

FILE: src/gdo_back.sv
`timescale 1ns / 1ps

module gdo_back #(
  parameter int BASE_YEAR = gdo_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = gdo_pkg::YEAR_SPAN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  gdo_pkg::item_t q_item,
  output logic           q_pop,
  gdo_out_if.source      out_ch
);

  localparam int YW_RAW = $clog2(BASE_YEAR + YEAR_SPAN + 1);
  localparam int YW     = (YW_RAW > gdo_pkg::YEAR_W) ? YW_RAW : gdo_pkg::YEAR_W;
  localparam int DW     = $clog2((YEAR_SPAN + 1) * 366 + 1);
  localparam int SW     = ((DW > gdo_pkg::OFF_W) ? DW : gdo_pkg::OFF_W) + 2;
  localparam int B4     = BASE_YEAR % 4;
  localparam int B100   = BASE_YEAR % 100;
  localparam int B400   = BASE_YEAR % 400;
  localparam int WB     = BASE_YEAR - 1;
  // Weekday of 1 January of the base year.
  localparam int W0     = (WB + WB / 4 - WB / 100 + WB / 400 + 1) % 7;

  gdo_pkg::state_t state_r, state_nxt;
  gdo_pkg::item_t  item_r, item_nxt;

  logic [YW-1:0]                yy_r, yy_nxt;
  logic [1:0]                   m4_r, m4_nxt;
  logic [6:0]                   m100_r, m100_nxt;
  logic [8:0]                   m400_r, m400_nxt;
  logic [gdo_pkg::MONTH_W-1:0]  mm_r, mm_nxt;
  logic signed [SW-1:0]         cnt_r, cnt_nxt;
  logic [gdo_pkg::WDAY_W-1:0]   wd_r, wd_nxt;
  logic [gdo_pkg::YDAY_W-1:0]   yday_r, yday_nxt;
  logic                         err_r, err_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [gdo_pkg::DAY_W-1:0]    o_day_r, o_day_nxt;
  logic [gdo_pkg::MONTH_W-1:0]  o_month_r, o_month_nxt;
  logic [gdo_pkg::YEAR_W-1:0]   o_year_r, o_year_nxt;
  logic [gdo_pkg::WDAY_W-1:0]   o_wday_r, o_wday_nxt;
  logic [gdo_pkg::YDAY_W-1:0]   o_yday_r, o_yday_nxt;
  logic                         o_err_r, o_err_nxt;

  logic                         leap;
  logic [8:0]                   ylen;
  logic [gdo_pkg::DAY_W-1:0]    mlen;
  logic [gdo_pkg::DAY_W-1:0]    in_mlen;
  logic                         year_match;
  logic                         year_longer;
  logic                         month_longer;
  logic signed [SW-1:0]         sum;
  logic                         out_free;

  function automatic logic [gdo_pkg::WDAY_W-1:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    return r[gdo_pkg::WDAY_W-1:0];
  endfunction

  // Leap status of yy_r comes from running remainders, so no division is needed.
  assign leap         = (m4_r == 2'd0) && ((m100_r != 7'd0) || (m400_r == 9'd0));
  assign ylen         = leap ? 9'd366 : 9'd365;
  assign mlen         = gdo_pkg::month_len(leap, mm_r);
  assign in_mlen      = gdo_pkg::month_len(leap, item_r.month);
  assign year_match   = (yy_r == YW'(item_r.year));
  assign year_longer  = (cnt_r > $signed(SW'(ylen)));
  assign month_longer = (cnt_r > $signed(SW'(mlen)));
  assign sum          = cnt_r + $signed(SW'(item_r.day)) + SW'(item_r.off);
  assign out_free     = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdo_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_item.bad ? gdo_pkg::ST_DONE : gdo_pkg::ST_YEAR_IN;
        end
      end
      gdo_pkg::ST_YEAR_IN: begin
        if (year_match) begin
          state_nxt = (item_r.day > in_mlen) ? gdo_pkg::ST_DONE : gdo_pkg::ST_MONTH_IN;
        end
      end
      gdo_pkg::ST_MONTH_IN: begin
        if (mm_r == item_r.month) begin
          state_nxt = gdo_pkg::ST_ADD;
        end
      end
      gdo_pkg::ST_ADD: begin
        state_nxt = (sum < $signed(SW'(1))) ? gdo_pkg::ST_DONE : gdo_pkg::ST_YEAR_OUT;
      end
      gdo_pkg::ST_YEAR_OUT: begin
        if (!year_longer) begin
          state_nxt = gdo_pkg::ST_MONTH_OUT;
        end else if (yy_r == YW'(BASE_YEAR + YEAR_SPAN - 1)) begin
          state_nxt = gdo_pkg::ST_DONE;
        end
      end
      gdo_pkg::ST_MONTH_OUT: begin
        if (!((mm_r < gdo_pkg::MONTH_W'(gdo_pkg::NUM_MONTHS)) && month_longer)) begin
          state_nxt = gdo_pkg::ST_DONE;
        end
      end
      gdo_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gdo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gdo_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    q_pop         = 1'b0;
    item_nxt      = item_r;
    yy_nxt        = yy_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    mm_nxt        = mm_r;
    cnt_nxt       = cnt_r;
    wd_nxt        = wd_r;
    yday_nxt      = yday_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_day_nxt     = o_day_r;
    o_month_nxt   = o_month_r;
    o_year_nxt    = o_year_r;
    o_wday_nxt    = o_wday_r;
    o_yday_nxt    = o_yday_r;
    o_err_nxt     = o_err_r;
    case (state_r)
      gdo_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          err_nxt  = q_item.bad;
          yy_nxt   = YW'(BASE_YEAR);
          m4_nxt   = 2'(B4);
          m100_nxt = 7'(B100);
          m400_nxt = 9'(B400);
          cnt_nxt  = '0;
        end
      end
      gdo_pkg::ST_YEAR_IN: begin
        if (year_match) begin
          mm_nxt = gdo_pkg::MONTH_W'(1);
          if (item_r.day > in_mlen) begin
            err_nxt = 1'b1;
          end
        end else begin
          cnt_nxt  = cnt_r + $signed(SW'(ylen));
          yy_nxt   = yy_r + YW'(1);
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == 7'd99)  ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
        end
      end
      gdo_pkg::ST_MONTH_IN: begin
        if (mm_r != item_r.month) begin
          cnt_nxt = cnt_r + $signed(SW'(mlen));
          mm_nxt  = mm_r + gdo_pkg::MONTH_W'(1);
        end
      end
      gdo_pkg::ST_ADD: begin
        if (sum < $signed(SW'(1))) begin
          err_nxt = 1'b1;
        end else begin
          cnt_nxt  = sum;
          yy_nxt   = YW'(BASE_YEAR);
          m4_nxt   = 2'(B4);
          m100_nxt = 7'(B100);
          m400_nxt = 9'(B400);
          wd_nxt   = gdo_pkg::WDAY_W'(W0);
        end
      end
      gdo_pkg::ST_YEAR_OUT: begin
        if (year_longer) begin
          cnt_nxt  = cnt_r - $signed(SW'(ylen));
          yy_nxt   = yy_r + YW'(1);
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == 7'd99)  ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
          wd_nxt   = mod7(6'(wd_r) + (leap ? 6'd2 : 6'd1));
          if (yy_r == YW'(BASE_YEAR + YEAR_SPAN - 1)) begin
            err_nxt = 1'b1;
          end
        end else begin
          mm_nxt   = gdo_pkg::MONTH_W'(1);
          yday_nxt = cnt_r[gdo_pkg::YDAY_W-1:0];
        end
      end
      gdo_pkg::ST_MONTH_OUT: begin
        if ((mm_r < gdo_pkg::MONTH_W'(gdo_pkg::NUM_MONTHS)) && month_longer) begin
          cnt_nxt = cnt_r - $signed(SW'(mlen));
          mm_nxt  = mm_r + gdo_pkg::MONTH_W'(1);
          // A month of 28 + k days moves the weekday on by k.
          wd_nxt  = mod7(6'(wd_r) + 6'(mlen - 5'd28));
        end else begin
          wd_nxt = mod7(6'(wd_r) + 6'(cnt_r[gdo_pkg::DAY_W-1:0]) - 6'd1);
        end
      end
      gdo_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_err_nxt     = err_r;
          if (err_r) begin
            o_day_nxt   = '0;
            o_month_nxt = '0;
            o_year_nxt  = '0;
            o_wday_nxt  = '0;
            o_yday_nxt  = '0;
          end else begin
            o_day_nxt   = cnt_r[gdo_pkg::DAY_W-1:0];
            o_month_nxt = mm_r;
            o_year_nxt  = yy_r[gdo_pkg::YEAR_W-1:0];
            o_wday_nxt  = wd_r;
            o_yday_nxt  = yday_r;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdo_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    yy_r      <= yy_nxt;
    m4_r      <= m4_nxt;
    m100_r    <= m100_nxt;
    m400_r    <= m400_nxt;
    mm_r      <= mm_nxt;
    cnt_r     <= cnt_nxt;
    wd_r      <= wd_nxt;
    yday_r    <= yday_nxt;
    err_r     <= err_nxt;
    o_day_r   <= o_day_nxt;
    o_month_r <= o_month_nxt;
    o_year_r  <= o_year_nxt;
    o_wday_r  <= o_wday_nxt;
    o_yday_r  <= o_yday_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_day      = o_day_r;
  assign out_ch.out_month    = o_month_r;
  assign out_ch.out_year     = o_year_r;
  assign out_ch.out_weekday  = o_wday_r;
  assign out_ch.out_year_day = o_yday_r;
  assign out_ch.error        = o_err_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_err_r) |-> ((o_day_r == '0) && (o_month_r == '0) &&
                                  (o_year_r == '0) && (o_yday_r == '0) &&
                                  (o_wday_r == '0)))
    else $error("error transaction carries nonzero fields");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_err_r) |-> ((o_month_r != '0) && (o_day_r != '0) &&
                                   (o_wday_r < 3'd7) && (o_yday_r != '0)))
    else $error("good transaction with out-of-range fields");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != gdo_pkg::ST_IDLE))
    else $error("engine stayed idle after taking a queued item");
`endif

endmodule

FILE: src/gregorian_date_offset_core.sv
`timescale 1ns / 1ps

// Adds a signed day offset to a Gregorian date and returns the new date, its day of year
// and its weekday (0 is Sunday), or the error flag with all other fields zero when the source
// date is invalid or the result leaves the years BASE_YEAR to BASE_YEAR + YEAR_SPAN - 1.
// A front stage checks each transaction and places it in a two-entry queue; a back engine
// walks the calendar one year or one month per clock. It works on one item at a time,
// while the queue goes on taking new transactions until it is full; the year-by-year
// walk sets how long an item takes.
module gregorian_date_offset_core #(
  parameter int BASE_YEAR = gdo_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = gdo_pkg::YEAR_SPAN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gdo_in_if.sink    in_ch,
  gdo_out_if.source out_ch
);

  logic           q_valid;
  logic           q_pop;
  gdo_pkg::item_t q_item;

  gdo_front #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  gdo_back #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [gdo_pkg::DAY_W-1:0]   day;
  logic [gdo_pkg::MONTH_W-1:0] month;
  logic [gdo_pkg::YEAR_W-1:0]  year;
  logic [gdo_pkg::WDAY_W-1:0]  wday;
  logic [gdo_pkg::YDAY_W-1:0]  yday;
  logic                        err;
} shifted_date_t;

class date_offset_scoreboard;
  localparam int FIRST_YEAR = gdo_pkg::BASE_YEAR_DEF;
  localparam int YEAR_END   = gdo_pkg::BASE_YEAR_DEF + gdo_pkg::YEAR_SPAN_DEF;

  shifted_date_t expected_dates[$];
  int mismatches;
  int dates_in;
  int dates_out;
  int flagged_out;

  function bit is_leap(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function int month_days(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function int year_days(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // Day count of a valid date, with 1 January of the first year as day 1.
  function int day_number(int d, int m, int y);
    int n;
    n = d;
    for (int k = 1; k < m; k++) n += month_days(k, y);
    for (int k = FIRST_YEAR; k < y; k++) n += year_days(k);
    return n;
  endfunction

  // Sakamoto's month term.
  function int month_shift(int m);
    case (m)
      1: return 0;  2: return 3;  3: return 2;  4: return 5;
      5: return 0;  6: return 3;  7: return 5;  8: return 1;
      9: return 4;  10: return 6; 11: return 2; default: return 4;
    endcase
  endfunction

  function shifted_date_t predict_shifted_date(int d, int m, int y, int off);
    shifted_date_t r;
    int n, yr, mo, rem, w;
    r = '0;
    r.err = 1'b1;
    if (y < FIRST_YEAR || y >= YEAR_END || m < 1 || m > 12) return r;
    if (d < 1 || d > month_days(m, y)) return r;
    n = day_number(d, m, y) + off;
    if (n < 1) return r;
    yr = FIRST_YEAR;
    while (n > year_days(yr)) begin
      n -= year_days(yr);
      yr++;
      if (yr >= YEAR_END) return r;
    end
    mo = 1;
    rem = n;
    while (mo < 12 && rem > month_days(mo, yr)) begin
      rem -= month_days(mo, yr);
      mo++;
    end
    w = (mo < 3) ? yr - 1 : yr;
    w = (w + w / 4 - w / 100 + w / 400 + month_shift(mo) + rem) % 7;
    r.err   = 1'b0;
    r.day   = rem[gdo_pkg::DAY_W-1:0];
    r.month = mo[gdo_pkg::MONTH_W-1:0];
    r.year  = yr[gdo_pkg::YEAR_W-1:0];
    r.wday  = w[gdo_pkg::WDAY_W-1:0];
    r.yday  = n[gdo_pkg::YDAY_W-1:0];
    return r;
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function int pending();
    return expected_dates.size();
  endfunction

  task note_input(int d, int m, int y, int off);
    expected_dates.push_back(predict_shifted_date(d, m, y, off));
    dates_in++;
  endtask

  task check_result(shifted_date_t got);
    shifted_date_t want;
    if (expected_dates.size() == 0) begin
      report_mismatch("unexpected result transaction", 1, 0);
      return;
    end
    want = expected_dates.pop_front();
    dates_out++;
    if (want.err) flagged_out++;
    if (got.err   !== want.err)   report_mismatch("error", got.err, want.err);
    if (got.day   !== want.day)   report_mismatch("out_day", got.day, want.day);
    if (got.month !== want.month) report_mismatch("out_month", got.month, want.month);
    if (got.year  !== want.year)  report_mismatch("out_year", got.year, want.year);
    if (got.wday  !== want.wday)  report_mismatch("out_weekday", got.wday, want.wday);
    if (got.yday  !== want.yday)  report_mismatch("out_year_day", got.yday, want.yday);
  endtask

  task check_drained();
    if (expected_dates.size() != 0)
      report_mismatch("results never delivered", 0, expected_dates.size());
  endtask
endclass

module tb;
  localparam int BASE = gdo_pkg::BASE_YEAR_DEF;
  localparam int SPAN = gdo_pkg::YEAR_SPAN_DEF;
  localparam int LAST_YEAR = BASE + SPAN - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_DATES = 545;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_enabled = 1'b1;
  int   stall_cycles = 0;

  gdo_in_if  in_ch();
  gdo_out_if out_ch();

  date_offset_scoreboard sb = new();

  gregorian_date_offset_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= !idle_enabled || ($urandom_range(99) >= 28);
  end

  // Values seen here are the ones from before the edge, so each transaction is
  // recorded exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.in_day, in_ch.in_month, in_ch.in_year, in_ch.offset_days);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{day: out_ch.out_day, month: out_ch.out_month,
                          year: out_ch.out_year, wday: out_ch.out_weekday,
                          yday: out_ch.out_year_day, err: out_ch.error});
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_date(int d, int m, int y, int off);
    while (idle_enabled && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_day      <= d[gdo_pkg::DAY_W-1:0];
    in_ch.in_month    <= m[gdo_pkg::MONTH_W-1:0];
    in_ch.in_year     <= y[gdo_pkg::YEAR_W-1:0];
    in_ch.offset_days <= off[gdo_pkg::OFF_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    int d, m, y, off, pick, last_day;
    logic signed [gdo_pkg::OFF_W-1:0] raw_off;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_day      <= '0;
    in_ch.in_month    <= '0;
    in_ch.in_year     <= '0;
    in_ch.offset_days <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    last_day = sb.day_number(31, 12, LAST_YEAR);

    // Range edges in both directions.
    send_date(1, 1, BASE, 0);
    send_date(1, 1, BASE, -1);
    send_date(31, 12, LAST_YEAR, 0);
    send_date(31, 12, LAST_YEAR, 1);
    send_date(1, 1, BASE, last_day - 1);
    send_date(1, 1, BASE, last_day);
    send_date(31, 12, LAST_YEAR, 1 - last_day);
    send_date(31, 12, LAST_YEAR, -last_day);
    send_date(1, 1, BASE, 262143);
    send_date(31, 12, LAST_YEAR, -262144);
    // Leap-year rules: divisible by 400, century years, ordinary years.
    send_date(29, 2, 2000, 0);
    send_date(29, 2, 1900, 0);
    send_date(29, 2, 2100, 5);
    send_date(29, 2, 2104, 365);
    send_date(28, 2, 2000, 1);
    send_date(1, 3, 2000, -1);
    send_date(31, 12, 1999, 1);
    // Malformed source dates, with one valid January date among them.
    send_date(0, 6, 2024, 10);
    send_date(31, 4, 2024, 0);
    send_date(31, 1, 2024, -31);
    send_date(15, 0, 2024, 0);
    send_date(15, 13, 2024, 0);
    send_date(15, 15, 2024, 0);
    send_date(15, 6, BASE - 1, 400);
    send_date(15, 6, 4095, -400);
    wait_all_results();

    for (int i = 0; i < RANDOM_DATES; i++) begin
      idle_enabled = !(i >= 200 && i < 300);
      if (i == 350) wait_all_results();
      raw_off = $urandom();
      if ($urandom_range(99) < 75) begin
        y = $urandom_range(LAST_YEAR, BASE);
        m = $urandom_range(12, 1);
        d = $urandom_range(sb.month_days(m, y), 1);
        pick = $urandom_range(4);
        case (pick)
          0: off = $urandom_range(800) - 400;
          1: off = $urandom_range(80000) - 40000;
          2: off = raw_off;
          3: off = 1 - sb.day_number(d, m, y) - $urandom_range(1);
          default: off = last_day - sb.day_number(d, m, y) + $urandom_range(1);
        endcase
      end else begin
        d = $urandom_range(31);
        m = $urandom_range(15);
        y = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(LAST_YEAR + 2, BASE - 2);
        off = raw_off;
      end
      send_date(d, m, y, off);
    end
    idle_enabled = 1'b1;

    wait_all_results();
    repeat (2 * SPAN + 64) @(posedge clk);
    sb.check_drained();

    $display("Ran %0d date transactions through the offset core, %0d results checked,",
             sb.dates_in, sb.dates_out);
    $display("%0d of them expected to carry the error flag.", sb.flagged_out);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
